// ===== src/psu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and the Paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 8192;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  localparam int BYTE_W    = 8;
  localparam int BPP_W     = 4;
  localparam int BPR_W     = 14;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STRIDE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW = 1'd1;

  localparam logic [BPP_W-1:0] BPP_RESET = 4'd4;
  localparam logic [BPR_W-1:0] BPR_RESET = 14'd1024;

  localparam logic [BYTE_W-1:0] FT_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] FT_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] FT_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] FT_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] FT_PAETH = 8'd4;

  typedef enum logic [2:0] {
    FLT_NONE,
    FLT_SUB,
    FLT_UP,
    FLT_AVG,
    FLT_PAETH,
    FLT_BAD
  } filter_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    filter_t           filter;
    logic              row_start;
    logic              first_row;
    logic              last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic filter_t classify(input logic [BYTE_W-1:0] code);
    filter_t f;
    case (code)
      FT_NONE:  f = FLT_NONE;
      FT_SUB:   f = FLT_SUB;
      FT_UP:    f = FLT_UP;
      FT_AVG:   f = FLT_AVG;
      FT_PAETH: f = FLT_PAETH;
      default:  f = FLT_BAD;
    endcase
    return f;
  endfunction

  function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [10:0]        pa;
    logic [10:0]        pb;
    logic [10:0]        pc;
    logic [BYTE_W-1:0]  res;
    da  = $signed({3'b000, b}) - $signed({3'b000, c});
    db  = $signed({3'b000, a}) - $signed({3'b000, c});
    dc  = da + db;
    pa  = da[10] ? 11'(-da) : 11'(da);
    pb  = db[10] ? 11'(-db) : 11'(db);
    pc  = dc[10] ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ===== src/png_scanline_unfilter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline reconstruction (None, Sub, Up, Average, Paeth) over a byte
// stream, with a line buffer holding the previous row.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one decompressed byte per
//   item. The first byte of each row is the filter type and yields no output;
//   every later byte yields one output item on out_valid/out_ready, with
//   row_end on the last byte of a row and bad_filter for filter types above 4.
//   image_start on a byte restarts the image; that byte is the filter type.
//   cfg_we/cfg_index/cfg_data set the pixel stride (index 0) and
//   bytes_per_row (index 1); write them only while no item is in flight.
//   From input accept to out_valid, an item is written into the queue, then
//   moves with its line-buffer read into the s1 stage register, and is then
//   loaded into the output register.
//   Throughput is one byte per cycle unless out_ready is low; the line buffer
//   has one write and one read port; the left loop closes via left_hist.
//   When the receiver stalls, the output register holds its item, the back
//   part stops, and the 4-entry queue fills before in_ready drops.
//   Reset clears row state and the configuration to 4 bytes per pixel and
//   1024 bytes per row; the line buffer is not cleared and is written by the
//   first row of each image before its contents are used.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psu_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psu_pkg::BYTE_W-1:0]    stream_byte,
  input  logic                          image_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psu_pkg::BYTE_W-1:0]    pixel_byte,
  output logic                          row_end,
  output logic                          bad_filter
);
  import psu_pkg::*;

  localparam int CW      = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int PW      = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int QW      = ENTRY_W + CW + PW;
  localparam int Q_DEPTH = 4;

  logic [BPP_W-1:0] pixel_stride;
  logic [BPR_W-1:0] bytes_per_row;

  logic          push;
  entry_t        push_entry;
  logic [CW-1:0] push_column;
  logic [PW-1:0] push_sel;
  logic [QW-1:0] q_head;
  logic          q_empty;
  logic          q_full;
  logic          q_pop;
  entry_t        q_entry;
  logic [CW-1:0] q_column;
  logic [PW-1:0] q_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_stride  <= BPP_RESET;
      bytes_per_row <= BPR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_STRIDE:  pixel_stride  <= cfg_data[BPP_W-1:0];
        REG_BYTES_PER_ROW: bytes_per_row <= cfg_data[BPR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;

  psu_front #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .CW              (CW),
    .PW              (PW)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .stream_byte     (stream_byte),
    .image_start     (image_start),
    .pixel_stride    (pixel_stride),
    .bytes_per_row   (bytes_per_row),
    .push            (push),
    .push_entry      (push_entry),
    .push_column     (push_column),
    .push_sel        (push_sel)
  );

  psu_queue #(
    .W     (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_entry, push_column, push_sel}),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {q_entry, q_column, q_sel} = q_head;

  psu_back #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .CW              (CW),
    .PW              (PW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (!q_empty),
    .q_entry    (q_entry),
    .q_column   (q_column),
    .q_sel      (q_sel),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_byte (pixel_byte),
    .row_end    (row_end),
    .bad_filter (bad_filter)
  );

endmodule

// ===== src/psu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_front
// Accepts stream bytes, tracks row position and filter type, and queues one
// classified entry per data byte.
// ----------------------------------------------------------------------------
module psu_front #(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  parameter int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [psu_pkg::BYTE_W-1:0]  stream_byte,
  input  logic                        image_start,
  input  logic [psu_pkg::BPP_W-1:0]   pixel_stride,
  input  logic [psu_pkg::BPR_W-1:0]   bytes_per_row,
  output logic                        push,
  output psu_pkg::entry_t             push_entry,
  output logic [CW-1:0]               push_column,
  output logic [PW-1:0]               push_sel
);
  import psu_pkg::*;

  localparam int CMPW = (CW + 1 > BPR_W) ? CW + 1 : BPR_W;

  logic [CW-1:0]   column;
  filter_t         row_filter;
  logic            awaiting_filter;
  logic            first_row;
  logic            accept;
  logic            awaiting_now;
  logic            first_now;
  logic [CMPW-1:0] len_eff;
  logic            last;

  assign accept       = in_valid && in_ready;
  assign awaiting_now = awaiting_filter || image_start;
  assign first_now    = first_row || image_start;

  always_comb begin
    if (bytes_per_row == '0) begin
      len_eff = CMPW'(1);
    end else if (32'(bytes_per_row) > MAX_ROW_BYTES) begin
      len_eff = CMPW'(MAX_ROW_BYTES);
    end else begin
      len_eff = CMPW'(bytes_per_row);
    end
  end

  always_comb begin
    if (pixel_stride == '0) begin
      push_sel = '0;
    end else if (32'(pixel_stride) > MAX_PIXEL_BYTES) begin
      push_sel = PW'(MAX_PIXEL_BYTES - 1);
    end else begin
      push_sel = PW'(pixel_stride - BPP_W'(1));
    end
  end

  assign last = (CMPW'(column) + CMPW'(1)) >= len_eff;

  assign push                 = accept && !awaiting_now;
  assign push_column          = column;
  assign push_entry.data      = stream_byte;
  assign push_entry.filter    = row_filter;
  assign push_entry.row_start = (column == '0);
  assign push_entry.first_row = first_now;
  assign push_entry.last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      row_filter      <= FLT_NONE;
      awaiting_filter <= 1'b1;
      first_row       <= 1'b1;
    end else if (accept) begin
      if (awaiting_now) begin
        row_filter      <= classify(stream_byte);
        awaiting_filter <= 1'b0;
        column          <= '0;
        first_row       <= first_now;
      end else if (last) begin
        awaiting_filter <= 1'b1;
        first_row       <= 1'b0;
        column          <= '0;
      end else begin
        column <= column + CW'(1);
      end
    end
  end

endmodule

// ===== src/psu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module psu_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (AW + 1)'(DEPTH));
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

endmodule

// ===== src/psu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_back
// Reads the upper row from the line buffer, reconstructs each byte from its
// left, upper and upper-left neighbors, and holds the result for the receiver.
// ----------------------------------------------------------------------------
module psu_back #(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF,
  parameter int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  parameter int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  psu_pkg::entry_t             q_entry,
  input  logic [CW-1:0]               q_column,
  input  logic [PW-1:0]               q_sel,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [psu_pkg::BYTE_W-1:0]  pixel_byte,
  output logic                        row_end,
  output logic                        bad_filter
);
  import psu_pkg::*;

  logic [BYTE_W-1:0] line_buf [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] left_hist [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] up_hist [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] left_eff [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] up_eff [MAX_PIXEL_BYTES];

  logic              s1_valid;
  entry_t            s1;
  logic [CW-1:0]     s1_column;
  logic [PW-1:0]     s1_sel;
  logic [BYTE_W-1:0] s1_upper;

  logic              advance;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] c;
  logic [BYTE_W:0]   sum_ab;
  logic [BYTE_W-1:0] pred;
  logic [BYTE_W-1:0] recon;

  assign advance = s1_valid && (!out_valid || out_ready);
  assign q_pop   = q_valid && (!s1_valid || advance);

  always_comb begin
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      left_eff[i] = s1.row_start ? '0 : left_hist[i];
      up_eff[i]   = s1.row_start ? '0 : up_hist[i];
    end
  end

  assign a      = left_eff[s1_sel];
  assign b      = s1.first_row ? '0 : s1_upper;
  assign c      = s1.first_row ? '0 : up_eff[s1_sel];
  assign sum_ab = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (s1.filter)
      FLT_NONE:  pred = '0;
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = sum_ab[BYTE_W:1];
      FLT_PAETH: pred = paeth_pick(a, b, c);
      default:   pred = '0;
    endcase
  end

  assign recon = s1.data + pred;

  always_ff @(posedge clk) begin
    if (advance) begin
      line_buf[s1_column] <= recon;
    end
    if (q_pop) begin
      if (advance && s1_column == q_column) begin
        s1_upper <= recon;
      end else begin
        s1_upper <= line_buf[q_column];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1        <= q_entry;
      s1_column <= q_column;
      s1_sel    <= q_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i] <= '0;
        up_hist[i]   <= '0;
      end
    end else if (advance) begin
      left_hist[0] <= recon;
      up_hist[0]   <= b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i] <= left_eff[i-1];
        up_hist[i]   <= up_eff[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_byte <= recon;
      row_end    <= s1.last;
      bad_filter <= (s1.filter == FLT_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
